/* sv/sti_pkg.sv */
// Shared types and constants for the sorted table block.
// Used by sti_ctrl, sti_datapath and the top level; no dependencies.
package sti_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_TOP,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      WA_IDX,
      WA_IDX_P1,
      WA_IDX_M1
   } wr_addr_type;

   typedef enum logic {
      WD_READ,
      WD_VALUE
   } wr_data_type;

   typedef enum logic {
      POS_IDX,
      POS_IDX_P1
   } pos_sel_type;

   typedef struct packed {
      logic        load;
      idx_op_type  idx_op;
      logic        rd_en;
      logic        wr_en;
      wr_addr_type wr_addr;
      wr_data_type wr_data;
      logic        res_hit;
      pos_sel_type pos_sel;
      logic        res_refuse;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        publish;
   } sti_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       ge;
      logic       eq;
      logic       idx_zero;
      logic       idx_last;
      logic       full;
      logic       empty;
      logic       out_busy;
   } sti_status_type;

endpackage

/* sv/sorted_table_insert_remove_search.sv */
// Channel  | Ports      | Payload
// ---------+------------+---------------------------------------------------------
// request  | req_t*     | tuser[1:0] kind; tdata[31:0] value
// response | rsp_t*     | tdata: [0] found, [4:1] position, [5] full_refused,
//          |            |        [10:6] entry_count, [15:11] zero
//
// One transaction at a time; the controller uses the table memory for one read or one
// write per cycle, which sets the time. Search reads slots upward to the slot reached.
// Insert walks down from the top, moving entries up; a remove hit moves later entries down.
// Full insert, remove or search on an empty table and unused kind go straight to the result.
// Synchronous reset empties the table at once. A stalled response keeps the controller
// waiting with the next result; a new request is taken while the last response waits.
// Top level of the sorted table; depends on sti_pkg, sti_ctrl and sti_datapath.
module sorted_table_insert_remove_search
   import sti_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // found, position[3:0], full_refused, entry_count[4:0]
);

   localparam int IDX_W = $clog2(CAPACITY + 1);

   sti_cmd_type      cmd;
   sti_status_type   status;
   logic [IDX_W-1:0] entry_count;

   sti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sti_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .status      (status),
      .entry_count (entry_count),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= IDX_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_found_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[5]))
      else $error("response both found and refused");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.wr_en)
      else $error("table written while idle");

endmodule

/* sv/sti_datapath.sv */
// Datapath of the sorted table: table memory, index, count, result and output registers.
// Depends on sti_pkg; driven by sti_ctrl through sti_cmd_type.
module sti_datapath
   import sti_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [31:0]                  req_tdata,   // [31:0] value
   input  logic [1:0]                   req_tuser,   // [1:0] kind
   input  sti_cmd_type                  cmd,
   output sti_status_type               status,
   output logic [$clog2(CAPACITY+1)-1:0] entry_count,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [15:0]                  rsp_tdata    // found, position[3:0], full_refused,
                                                     // entry_count[4:0], zero fill
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int IDX_W  = $clog2(CAPACITY + 1);

   logic [31:0]        mem [CAPACITY];
   logic signed [31:0] rd_ff;
   logic signed [31:0] value_ff;
   logic [1:0]         kind_ff;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]   count_ff, count_in, count_m1;
   logic               found_ff, refused_ff;
   logic [ADDR_W-1:0]  pos_ff, pos_val;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        wr_data;
   logic               rsp_valid_ff, rsp_found_ff, rsp_refused_ff;
   logic [3:0]         rsp_pos_ff;
   logic [4:0]         rsp_count_ff;
   logic [ADDR_W+3:0]  pos_wide;
   logic [IDX_W+4:0]   count_wide;

   assign count_m1 = count_ff - IDX_W'(1);

   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_TOP:  idx_in = count_m1[ADDR_W-1:0];
         IDX_INC:  idx_in = idx_ff + ADDR_W'(1);
         IDX_DEC:  idx_in = idx_ff - ADDR_W'(1);
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_addr)
         WA_IDX_P1: wr_addr = idx_ff + ADDR_W'(1);
         WA_IDX_M1: wr_addr = idx_ff - ADDR_W'(1);
         default:   wr_addr = idx_ff;
      endcase
   end

   assign wr_data = (cmd.wr_data == WD_VALUE) ? value_ff : rd_ff;
   assign pos_val = (cmd.pos_sel == POS_IDX_P1) ? idx_ff + ADDR_W'(1) : idx_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + IDX_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end
   end

   // table memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         value_ff <= req_tdata;
         kind_ff  <= req_tuser;
      end
      if (cmd.res_hit) begin
         found_ff <= 1'b1;
         pos_ff   <= pos_val;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end
      if (cmd.res_refuse) begin
         refused_ff <= 1'b1;
      end else if (cmd.load) begin
         refused_ff <= 1'b0;
      end
      if (cmd.publish) begin
         rsp_found_ff   <= found_ff;
         rsp_pos_ff     <= pos_wide[3:0];
         rsp_refused_ff <= refused_ff;
         rsp_count_ff   <= count_wide[4:0];
      end
   end

   assign pos_wide   = (ADDR_W + 4)'(pos_ff);
   assign count_wide = (IDX_W + 5)'(count_ff);

   assign status.kind     = kind_ff;
   assign status.ge       = rd_ff >= value_ff;
   assign status.eq       = rd_ff == value_ff;
   assign status.idx_zero = idx_ff == '0;
   assign status.idx_last = (IDX_W'(idx_ff) + IDX_W'(1)) == count_ff;
   assign status.full     = count_ff == IDX_W'(CAPACITY);
   assign status.empty    = count_ff == '0;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign entry_count = count_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {5'd0, rsp_count_ff, rsp_refused_ff, rsp_pos_ff, rsp_found_ff};

endmodule

/* sv/sti_ctrl.sv */
// Controller of the sorted table: sequences scan, shift and result transactions.
// Depends on sti_pkg; drives sti_datapath through sti_cmd_type.
module sti_ctrl
   import sti_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic [1:0]     req_kind,
   output logic           req_tready,
   input  sti_status_type status,
   output sti_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_I_RD,
      S_I_CMP,
      S_I_PUT0,
      S_S_RD,
      S_S_CMP,
      S_R_RD,
      S_R_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (req_kind) inside
                  KIND_INSERT: begin
                     if (status.full) begin
                        cmd.res_refuse = 1'b1;
                        state_in       = S_DONE;
                     end else if (status.empty) begin
                        cmd.idx_op = IDX_ZERO;
                        state_in   = S_I_PUT0;
                     end else begin
                        cmd.idx_op = IDX_TOP;
                        state_in   = S_I_RD;
                     end
                  end
                  KIND_REMOVE, KIND_SEARCH: begin
                     if (status.empty) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.idx_op = IDX_ZERO;
                        state_in   = S_S_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_I_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_I_CMP;
         end
         S_I_CMP: begin
            // walk down from the top, moving larger-or-equal entries up one
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_IDX_P1;
            if (status.ge) begin
               cmd.wr_data = WD_READ;
               if (status.idx_zero) begin
                  state_in = S_I_PUT0;
               end else begin
                  cmd.idx_op = IDX_DEC;
                  state_in   = S_I_RD;
               end
            end else begin
               cmd.wr_data = WD_VALUE;
               cmd.res_hit = 1'b1;
               cmd.pos_sel = POS_IDX_P1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_I_PUT0: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_IDX;
            cmd.wr_data = WD_VALUE;
            cmd.res_hit = 1'b1;
            cmd.pos_sel = POS_IDX;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_S_CMP;
         end
         S_S_CMP: begin
            if (!status.ge) begin
               if (status.idx_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_S_RD;
               end
            end else if (status.eq) begin
               cmd.res_hit = 1'b1;
               cmd.pos_sel = POS_IDX;
               if (status.kind == KIND_REMOVE) begin
                  if (status.idx_last) begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_DONE;
                  end else begin
                     cmd.idx_op = IDX_INC;
                     state_in   = S_R_RD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_R_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_R_WR;
         end
         S_R_WR: begin
            // close the gap: move each later entry down one
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_IDX_M1;
            cmd.wr_data = WD_READ;
            if (status.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_R_RD;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_insert_remove_search: directed table, then random
// insert/remove/search/unused-kind traffic checked against a local sorted table. Needs sti_pkg and the RTL.
module testbench
   import sti_pkg::*;
();

   localparam int         SLOTS        = CAPACITY_DEF;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1500;
   localparam int         IDLE_LIMIT   = 4000;
   localparam int         DRAIN_CYCLES = 2 * SLOTS + 8;
   localparam int         MAX_REPORTS  = 10;
   localparam int         DIRECTED_LEN = 26;

   typedef struct packed {
      logic       found;
      logic [3:0] position;
      logic       full_refused;
      logic [4:0] entry_count;
   } table_result_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [31:0]      value;
      logic             typed;
      table_result_type result;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // found, position[3:0], full_refused, entry_count[4:0]

   logic signed [31:0] table_vals [SLOTS];
   int unsigned        table_len   = 0;
   table_result_type   expected_results [$];
   int                 mismatches  = 0;
   int                 idle_cycles = 0;
   int                 burst_left  = 0;
   logic [9:0]         stall_phase = '0;

   // typed rows: empty table, extremes, full-table refusal
   directed_row_type directed_rows [DIRECTED_LEN] = '{
      '{KIND_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
      '{KIND_REMOVE, 32'h1234_5678, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
      '{KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd0, 1'b0, 5'd1}},
      '{KIND_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 1'b0, 5'd2}},
      '{KIND_INSERT, 32'h0000_0000, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_0000, 1'b0, '0},
      '{KIND_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_0001, 1'b0, '0},
      '{KIND_INSERT, 32'h5555_5555, 1'b0, '0},
      '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
      '{KIND_INSERT, 32'h8000_0000, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_0064, 1'b0, '0},
      '{KIND_INSERT, 32'hFFFF_FF9C, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_FFFF, 1'b0, '0},
      '{KIND_INSERT, 32'hFFFF_0000, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_002A, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_0007, 1'b0, '0},
      '{KIND_INSERT, 32'h0000_0003, 1'b1, '{1'b0, 4'd0, 1'b1, 5'd16}},
      '{KIND_SEARCH, 32'h0000_0000, 1'b0, '0},
      '{KIND_SEARCH, 32'h8000_0000, 1'b0, '0},
      '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
      '{KIND_SEARCH, 32'h0000_3039, 1'b0, '0},
      '{KIND_UNUSED, 32'h0000_0000, 1'b0, '0},
      '{KIND_REMOVE, 32'h0000_03E7, 1'b0, '0}
   };

   sorted_table_insert_remove_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic table_result_type table_apply(input logic [1:0] kind,
                                                    input logic signed [31:0] value);
      table_result_type res;
      int unsigned      slot;
      int unsigned      j;
      logic             hit;
      res  = '0;
      slot = 0;
      while (slot < table_len && table_vals[slot] < value) slot++;
      hit = (slot < table_len) && (table_vals[slot] == value);
      case (kind)
         KIND_INSERT: begin
            if (table_len >= SLOTS) begin
               res.full_refused = 1'b1;
            end else begin
               for (j = table_len; j > slot; j--) table_vals[j] = table_vals[j - 1];
               table_vals[slot] = value;
               table_len++;
               res.found    = 1'b1;
               res.position = slot[3:0];
            end
         end
         KIND_REMOVE: begin
            if (hit) begin
               for (j = slot; j + 1 < table_len; j++) table_vals[j] = table_vals[j + 1];
               table_len--;
               res.found    = 1'b1;
               res.position = slot[3:0];
            end
         end
         KIND_SEARCH: begin
            if (hit) begin
               res.found    = 1'b1;
               res.position = slot[3:0];
            end
         end
         default: begin
         end
      endcase
      res.entry_count = table_len[4:0];
      return res;
   endfunction

   function automatic logic [1:0] pick_kind(input int item);
      int unsigned r;
      r = $urandom_range(0, 99);
      // alternate fill-heavy and drain-heavy stretches so the table swings empty to full
      if ((item / 120) % 2 == 0) begin
         if (r < 55) return KIND_INSERT;
         if (r < 75) return KIND_REMOVE;
         if (r < 95) return KIND_SEARCH;
      end else begin
         if (r < 20) return KIND_INSERT;
         if (r < 65) return KIND_REMOVE;
         if (r < 95) return KIND_SEARCH;
      end
      return KIND_UNUSED;
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 15) - 8;
      if (r < 70 && table_len > 0) return table_vals[$urandom_range(0, table_len - 1)];
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [31:0] value,
                            input logic typed, input table_result_type typed_result);
      int               gap;
      table_result_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = table_apply(kind, value);
      expected_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (expected_results.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input table_result_type want,
                                  input table_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch (%s): %s, %s", $realtime, what,
                  $sformatf("expected found=%0b pos=%0d refused=%0b count=%0d",
                            want.found, want.position, want.full_refused,
                            want.entry_count),
                  $sformatf("got found=%0b pos=%0d refused=%0b count=%0d",
                            got.found, got.position, got.full_refused,
                            got.entry_count));
   endtask

   always @(negedge clock) begin
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      table_result_type got;
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[4:1], rsp_tdata[5], rsp_tdata[10:6]};
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found || got.position !== want.position ||
                got.full_refused !== want.full_refused ||
                got.entry_count !== want.entry_count)
               report_mismatch("field", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].result);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_drained();
         send_item(pick_kind(n), pick_value(), 1'b0, '0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sorted_table_insert_remove_search.f */
sv/sti_pkg.sv
sv/sti_datapath.sv
sv/sti_ctrl.sv
sv/sorted_table_insert_remove_search.sv
test/testbench.sv
